// ----- rtl/core/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 16;
  localparam int DEF_ADDRESS_BITS      = 48;

  localparam int BYTE_BITS      = 8;
  localparam int CFG_BYTES      = 16;  // pattern bytes held in the registers
  localparam int CFG_BYTE_BITS  = 4;   // index into the configured pattern bytes
  localparam int PAT_POS_BITS   = 7;   // pattern position, covers up to 128 cells
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int COUNT_BITS     = 16;
  localparam int LENGTH_BITS    = 5;

  localparam logic [15:0] CARE_MASK_RESET = 16'hFFFF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_CARE_MASK    = 3'd2,
    CFG_PATTERN_LEN  = 3'd3,
    CFG_MAX_MATCHES  = 3'd4
  } cfg_reg_t;

  // pattern byte a cell compares against, and whether it counts
  typedef struct packed {
    logic                 cared;
    logic [BYTE_BITS-1:0] value;
  } cell_ref_t;

endpackage

// ----- rtl/core/mbps_cell.sv -----
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: holds it, hands it to the next cell, compares the byte
// it takes in against its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 shift,
  input  logic [BYTE_BITS-1:0] byte_in,
  input  cell_ref_t            ref_in,
  output logic [BYTE_BITS-1:0] byte_out,
  output logic                 mismatch
);

  logic [BYTE_BITS-1:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign mismatch = ref_in.cared && (byte_in != ref_in.value);

endmodule

// ----- rtl/core/masked_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams memory bytes through a row of compare cells and reports every
// (possibly overlapping) window that matches the masked pattern.
// ----------------------------------------------------------------------------
// One byte is taken per clock while s_tready is high; a match beat is registered
// in the output register, or in the skid while that is held. All byte compares
// run in parallel in the cell row, so the rate is one beat per cycle as long as
// the master side keeps up; a two-entry output stage (register plus skid) absorbs
// one stalled result before the slave side stops. No clearing pass after reset.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = DEF_ADDRESS_BITS,
  localparam int InBits  = ((BYTE_BITS + ADDRESS_BITS + 7) / 8) * 8,
  localparam int OutBits = ((ADDRESS_BITS + COUNT_BITS + 7) / 8) * 8
)
(
  input  logic                      clk,
  input  logic                      rst,
  // slave side
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [InBits-1:0]         s_tdata,   // data_byte, byte_address, zero pad
  input  logic [1:0]                s_tuser,   // region_first, scan_first
  // master side
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OutBits-1:0]        m_tdata,   // match_address, match_index, zero pad
  output logic [0:0]                m_tuser,   // limit_reached
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FillBits = $clog2(MAX_PATTERN_BYTES + 1);

  // configuration
  logic [63:0]            pattern_low;
  logic [63:0]            pattern_high;
  logic [15:0]            care_mask;
  logic [LENGTH_BITS-1:0] pattern_length;
  logic [COUNT_BITS-1:0]  max_matches;

  // scan state
  logic [FillBits-1:0]    window_fill;
  logic [COUNT_BITS-1:0]  match_count;

  // output stage
  logic [ADDRESS_BITS-1:0] out_address, skid_address;
  logic [COUNT_BITS-1:0]   out_index, skid_index;
  logic                    out_limit, skid_limit;
  logic                    skid_valid;

  logic [BYTE_BITS-1:0]    data_byte;
  logic [ADDRESS_BITS-1:0] byte_address;
  logic                    region_first, scan_first;

  logic                    accept, out_fire;
  logic [FillBits-1:0]     len_eff, fill_cur, fill_next;
  logic [COUNT_BITS-1:0]   count_cur, count_inc, match_count_next;
  logic                    fill_ok, limit_block, hit, res_valid;
  logic [ADDRESS_BITS-1:0] res_address;
  logic                    res_limit;

  logic [BYTE_BITS-1:0]    pat_arr  [CFG_BYTES];
  logic [BYTE_BITS-1:0]    win      [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] mismatch;

  assign data_byte    = s_tdata[BYTE_BITS-1:0];
  assign byte_address = s_tdata[BYTE_BITS +: ADDRESS_BITS];
  assign region_first = s_tuser[0];
  assign scan_first   = s_tuser[1];

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= CARE_MASK_RESET;
      pattern_length <= LENGTH_BITS'(1);
      max_matches    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_LOW:  pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high   <= cfg_data;
        CFG_CARE_MASK:    care_mask      <= cfg_data[15:0];
        CFG_PATTERN_LEN:  pattern_length <= cfg_data[LENGTH_BITS-1:0];
        CFG_MAX_MATCHES:  max_matches    <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = FillBits'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN_BYTES)) begin
      len_eff = FillBits'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = FillBits'(pattern_length);
    end
  end

  always_comb begin
    for (int i = 0; i < CFG_BYTES; i++) begin
      if (i < 8) begin
        pat_arr[i] = pattern_low[i*BYTE_BITS +: BYTE_BITS];
      end else begin
        pat_arr[i] = pattern_high[(i-8)*BYTE_BITS +: BYTE_BITS];
      end
    end
  end

  // cell j takes in the byte j beats old; it lines up with pattern byte len-1-j
  for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    logic [PAT_POS_BITS-1:0] pos;
    cell_ref_t               cref;
    logic [BYTE_BITS-1:0]    byte_in;

    assign pos = PAT_POS_BITS'(len_eff) - PAT_POS_BITS'(j + 1);
    assign cref.cared = (32'(j) < 32'(len_eff)) && (32'(pos) < CFG_BYTES)
                        && care_mask[pos[CFG_BYTE_BITS-1:0]];
    assign cref.value = pat_arr[pos[CFG_BYTE_BITS-1:0]];

    if (j == 0) begin : g_head
      assign byte_in = data_byte;
    end else begin : g_body
      assign byte_in = win[j-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (byte_in),
      .ref_in   (cref),
      .byte_out (win[j]),
      .mismatch (mismatch[j])
    );
  end

  always_comb begin
    fill_cur  = region_first ? '0 : window_fill;
    fill_next = (32'(fill_cur) >= 32'(MAX_PATTERN_BYTES)) ? fill_cur
                                                           : fill_cur + FillBits'(1);
    count_cur = scan_first ? '0 : match_count;
    count_inc = count_cur + COUNT_BITS'(1);
    fill_ok     = fill_next >= len_eff;
    limit_block = (max_matches != '0) && (count_cur >= max_matches);
    hit         = fill_ok && !limit_block && !(|mismatch);
    res_valid   = accept && hit;
    res_address = byte_address - (ADDRESS_BITS'(len_eff) - ADDRESS_BITS'(1));
    res_limit   = (max_matches != '0) && (count_inc == max_matches);
    match_count_next = hit ? count_inc : count_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
      match_count <= '0;
    end else if (accept) begin
      window_fill <= fill_next;
      match_count <= match_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!m_tvalid || out_fire) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_address <= skid_address;
        out_index   <= skid_index;
        out_limit   <= skid_limit;
      end
    end else if (res_valid) begin
      if (!m_tvalid || out_fire) begin
        out_address <= res_address;
        out_index   <= count_cur;
        out_limit   <= res_limit;
      end else begin
        skid_address <= res_address;
        skid_index   <= count_cur;
        skid_limit   <= res_limit;
      end
    end
  end

  assign m_tdata = OutBits'({out_index, out_address});
  assign m_tuser = out_limit;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while output register empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(window_fill) <= 32'(MAX_PATTERN_BYTES))
    else $error("window fill beyond cell count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !scan_first) |=> (match_count == $past(match_count))
      || (match_count == $past(match_count) + COUNT_BITS'(1)))
    else $error("match count moved by more than one");
`endif

endmodule

// ----- tb/tb_masked_byte_pattern_scanner.sv -----
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner
// Self-checking bench for the masked byte pattern scanner. A directed table
// covers reset values, field extremes, clamped lengths, match limits and
// window restarts. Random phases of planted and noisy byte streams follow.
// Results are checked against an in-bench window model or given table values.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner;
  import mbps_pkg::*;

  localparam int AW       = DEF_ADDRESS_BITS;
  localparam int WIN      = DEF_MAX_PATTERN_BYTES;
  localparam int IN_BITS  = ((BYTE_BITS + AW + 7) / 8) * 8;
  localparam int OUT_BITS = ((AW + COUNT_BITS + 7) / 8) * 8;
  localparam int SETTLE   = 4;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = '1;

  typedef struct packed {
    logic [AW-1:0]         addr;
    logic [COUNT_BITS-1:0] index;
    logic                  limit;
  } match_t;

  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_src_t;
  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
    logic [BYTE_BITS-1:0]      d;
    logic [AW-1:0]             a;
    logic                      rf;
    logic                      sf;
    exp_src_t                  src;
    match_t                    m;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_BITS-1:0]        s_tdata;
  logic [1:0]                s_tuser;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_BITS-1:0]       m_tdata;
  logic [0:0]                m_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  masked_byte_pattern_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window model state and its copy of the registers
  logic [CFG_DATA_BITS-1:0] pat_lo, pat_hi;
  logic [15:0]              care;
  logic [LENGTH_BITS-1:0]   plen;
  logic [COUNT_BITS-1:0]    cap;
  logic [BYTE_BITS-1:0]     win [WIN];
  int unsigned              win_fill;
  logic [COUNT_BITS-1:0]    hit_count;

  match_t   pending_matches [$];
  row_t     plan [$];
  int       mismatches = 0;
  int       random_sent = 0;
  int       stall_left = 0;
  bit       quiet = 1'b0;
  bit       paused_once = 1'b0;
  exp_src_t row_src = EXP_MODEL;
  match_t   row_match = '0;
  logic [AW-1:0] scan_addr = '0;

  function automatic bit window_match(input logic [BYTE_BITS-1:0] d, input logic [AW-1:0] a,
                                      input logic rf, input logic sf, output match_t m);
    int unsigned n;
    int          i;
    bit          ok;
    logic [BYTE_BITS-1:0] pb;
    m = '0;
    n = (plen == 0) ? 1 : 32'(plen);
    if (n > WIN) n = WIN;
    if (sf) hit_count = '0;
    if (rf) win_fill = 0;
    for (i = WIN - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = d;
    if (win_fill < WIN) win_fill++;
    if (win_fill < n) return 1'b0;
    if (cap != 0 && hit_count >= cap) return 1'b0;
    ok = 1'b1;
    for (i = 0; i < n; i++) begin
      if (i < 8) pb = pat_lo[8*i +: 8];
      else pb = pat_hi[8*(i-8) +: 8];
      if (i < CFG_BYTES && care[i] && win[n-1-i] != pb) ok = 1'b0;
    end
    if (!ok) return 1'b0;
    m.addr  = a - AW'(n - 1);
    m.index = hit_count;
    hit_count++;
    m.limit = (cap != 0 && hit_count == cap);
    return 1'b1;
  endfunction

  task automatic flag(input string what, input logic [63:0] seen, input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s: got %0h want %0h at %0t", what, seen, want, $time);
  endtask

  always @(posedge clk) begin : watch
    match_t m;
    match_t got;
    match_t want;
    bit     hit;
    if (rst) begin
      pat_lo = '0;
      pat_hi = '0;
      care = CARE_MASK_RESET;
      plen = 5'd1;
      cap = '0;
      foreach (win[i]) win[i] = '0;
      win_fill = 0;
      hit_count = '0;
      pending_matches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LOW:  pat_lo = cfg_data;
          CFG_PATTERN_HIGH: pat_hi = cfg_data;
          CFG_CARE_MASK:    care = cfg_data[15:0];
          CFG_PATTERN_LEN:  plen = cfg_data[LENGTH_BITS-1:0];
          CFG_MAX_MATCHES:  cap = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        hit = window_match(s_tdata[BYTE_BITS-1:0], s_tdata[BYTE_BITS +: AW],
                           s_tuser[0], s_tuser[1], m);
        case (row_src)
          EXP_MODEL: if (hit) pending_matches.insert(pending_matches.size(), m);
          EXP_GIVEN: pending_matches.insert(pending_matches.size(), row_match);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.addr  = m_tdata[AW-1:0];
        got.index = m_tdata[AW +: COUNT_BITS];
        got.limit = m_tuser[0];
        if (pending_matches.size() == 0) begin
          flag("match beat with none pending", m_tdata, '0);
        end else begin
          want = pending_matches.pop_front();
          if (got.addr !== want.addr)
            flag("match_address", 64'(got.addr), 64'(want.addr));
          if (got.index !== want.index)
            flag("match_index", 64'(got.index), 64'(want.index));
          if (got.limit !== want.limit)
            flag("limit_reached", 64'(got.limit), 64'(want.limit));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at a falling edge with valid still up
  task automatic put_byte(input logic [BYTE_BITS-1:0] d, input logic [AW-1:0] a,
                          input logic rf, input logic sf, input exp_src_t src,
                          input match_t m);
    int gap;
    logic [IN_BITS-1:0] beat;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    beat = '0;
    beat[BYTE_BITS-1:0] = d;
    beat[BYTE_BITS +: AW] = a;
    row_src = src;
    row_match = m;
    s_tvalid <= 1'b1;
    s_tdata <= beat;
    s_tuser <= {sf, rf};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, val: val, d: '0, a: '0, rf: 1'b0, sf: 1'b0,
          src: EXP_NONE, m: '0};
    plan.insert(plan.size(), r);
  endfunction

  function automatic void add_byte(input logic [BYTE_BITS-1:0] d, input logic [AW-1:0] a,
                                   input logic rf, input logic sf, input exp_src_t src,
                                   input logic [AW-1:0] ea, input logic [15:0] ei,
                                   input logic el);
    row_t r;
    r = '{kind: ROW_BYTE, idx: '0, val: '0, d: d, a: a, rf: rf, sf: sf, src: src,
          m: '{addr: ea, index: ei, limit: el}};
    plan.insert(plan.size(), r);
  endfunction

  task automatic random_phase();
    logic [BYTE_BITS-1:0] pat [CFG_BYTES];
    logic [BYTE_BITS-1:0] sym0, sym1, d;
    logic [CFG_DATA_BITS-1:0] lo, hi, junk;
    logic [15:0] care_v, max_v;
    logic [LENGTH_BITS-1:0] len_v;
    int eff, items, plant, r, k, n;
    bit narrow, rf, sf;
    quiet = ($urandom_range(0, 4) == 0);
    narrow = ($urandom_range(0, 1) == 1);
    sym0 = BYTE_BITS'($urandom);
    sym1 = BYTE_BITS'($urandom);
    for (k = 0; k < CFG_BYTES; k++)
      pat[k] = narrow ? ($urandom_range(0, 1) ? sym1 : sym0) : BYTE_BITS'($urandom);
    for (k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat[k];
      hi[8*k +: 8] = pat[k+8];
    end
    r = $urandom_range(0, 99);
    if (r < 70) len_v = LENGTH_BITS'($urandom_range(1, 6));
    else if (r < 90) len_v = LENGTH_BITS'($urandom_range(7, 16));
    else len_v = LENGTH_BITS'($urandom_range(0, 31));
    eff = (len_v == 0) ? 1 : ((len_v > WIN) ? WIN : 32'(len_v));
    r = $urandom_range(0, 99);
    if (r < 30) care_v = 16'hFFFF;
    else if (r < 40) care_v = '0;
    else care_v = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) max_v = '0;
    else if (r < 90) max_v = 16'($urandom_range(1, 6));
    else if (r < 95) max_v = 16'hFFFF;
    else max_v = 16'($urandom);
    junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_CARE_MASK, {junk[63:16], care_v});
    write_reg(CFG_PATTERN_LEN, {junk[63:LENGTH_BITS], len_v});
    write_reg(CFG_MAX_MATCHES, {junk[63:16], max_v});
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_INDEX_BITS'($urandom_range(32'(CFG_MAX_MATCHES) + 1, 32'(CFG_SPARE))),
                {$urandom, $urandom});
    items = $urandom_range(30, 120);
    plant = -1;
    for (n = 0; n < items; n++) begin
      rf = (n == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 39) == 0);
      sf = (n == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 79) == 0);
      r = $urandom_range(0, 99);
      if (r < 90) scan_addr = scan_addr + 1'b1;
      else if (r < 95) scan_addr = AW'({$urandom, $urandom});
      else scan_addr = {{(AW-8){1'b1}}, 8'($urandom_range(240, 255))};
      if (plant < 0 && $urandom_range(0, 5) == 0) plant = 0;
      if (plant >= 0) begin
        d = care_v[plant] ? pat[plant] : BYTE_BITS'($urandom);
        plant++;
        if (plant == eff) plant = -1;
      end else if (narrow && $urandom_range(0, 9) != 0) begin
        d = $urandom_range(0, 1) ? sym1 : sym0;
      end else if (!narrow && $urandom_range(0, 3) == 0) begin
        d = pat[$urandom_range(0, CFG_BYTES - 1)];
      end else begin
        d = BYTE_BITS'($urandom);
      end
      if ((!paused_once && n == items / 2) || $urandom_range(0, 299) == 0) begin
        settle_idle();
        paused_once = 1'b1;
      end
      put_byte(d, scan_addr, rf, sf, EXP_MODEL, '0);
      random_sent++;
    end
  endtask

  initial begin : stim
    int k;
    logic [AW-1:0] top;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    top = '1;

    // reset registers: zero pattern, all bytes cared, length one, no limit
    add_byte(8'h00, '0, 1'b1, 1'b1, EXP_GIVEN, '0, 16'd0, 1'b0);
    add_byte(8'hFF, top, 1'b0, 1'b0, EXP_NONE, '0, '0, 1'b0);
    add_byte(8'h00, top, 1'b0, 1'b0, EXP_GIVEN, top, 16'd1, 1'b0);
    add_reg(CFG_SPARE, '1);
    add_reg(CFG_PATTERN_LEN, '0);
    add_byte(8'h00, AW'(16), 1'b0, 1'b1, EXP_GIVEN, AW'(16), 16'd0, 1'b0);
    // all wildcards, oversized length, limit of two, window spanning address wrap
    add_reg(CFG_PATTERN_LOW, '1);
    add_reg(CFG_PATTERN_HIGH, 64'h0123_4567_89AB_CDEF);
    add_reg(CFG_CARE_MASK, '0);
    add_reg(CFG_PATTERN_LEN, 64'd31);
    add_reg(CFG_MAX_MATCHES, 64'd2);
    for (k = 0; k < 15; k++)
      add_byte(k[0] ? 8'hFF : 8'h00, top - AW'(7) + AW'(k), k == 0, k == 0, EXP_MODEL,
               '0, '0, 1'b0);
    add_byte(8'hFF, AW'(7), 1'b0, 1'b0, EXP_GIVEN, top - AW'(7), 16'd0, 1'b0);
    add_byte(8'h00, AW'(8), 1'b0, 1'b0, EXP_GIVEN, top - AW'(6), 16'd1, 1'b1);
    add_byte(8'hA5, AW'(9), 1'b0, 1'b0, EXP_NONE, '0, '0, 1'b0);
    add_byte(8'h5A, AW'(10), 1'b0, 1'b1, EXP_GIVEN, top - AW'(4), 16'd0, 1'b0);
    add_reg(CFG_MAX_MATCHES, 64'd1);
    add_byte(8'hFF, AW'(11), 1'b0, 1'b0, EXP_NONE, '0, '0, 1'b0);
    add_byte(8'h00, AW'(12), 1'b1, 1'b1, EXP_NONE, '0, '0, 1'b0);

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].val);
      else put_byte(plan[i].d, plan[i].a, plan[i].rf, plan[i].sf, plan[i].src, plan[i].m);
    end

    while (random_sent < RANDOM_ITEMS) random_phase();
    quiet = 1'b0;

    settle_idle();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending_matches.size() == 0)
      $display("tb_masked_byte_pattern_scanner: clean");
    else
      $display("tb_masked_byte_pattern_scanner: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_masked_byte_pattern_scanner: errors");
    $finish;
  end

endmodule

// ----- masked_byte_pattern_scanner.f -----
rtl/core/mbps_pkg.sv
rtl/core/mbps_cell.sv
rtl/core/masked_byte_pattern_scanner.sv
tb/tb_masked_byte_pattern_scanner.sv
